[design/tbsd_pkg.sv]
// package for the timing bit slicer and deframer
// register indexes, widths, reset values and default parameters; no dependencies
`timescale 1ns / 1ps

package tbsd_pkg;

  localparam int unsigned TIME_W          = 16;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned SYNC_WORD_W     = 6;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam int unsigned MAX_MSG_BITS_DEF = 1024;
  localparam int unsigned SYNC_BITS_DEF    = 6;

  localparam logic [CNT_W-1:0]       MISS_THRESHOLD_RST  = 16'd100;
  localparam logic [CNT_W-1:0]       SAMPLES_PER_BIT_RST = 16'd64;
  localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST       = 6'b101011;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_THRESHOLD  = 2'd0,
    CFG_SAMPLES_PER_BIT = 2'd1,
    CFG_SYNC_WORD       = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_t;

endpackage

[design/timing_bit_slicer_deframer_core.sv]
// timing bit slicer and deframer, top level
// depends on tbsd_pkg for register indexes, widths and reset values
`timescale 1ns / 1ps

// usage:
// in_*  : one access-time sample per transaction (valid/ready)
// out_* : one result per completed message byte, end marker or truncation
// cfg_* : write-only register port, written while the block is idle
//   index 0 miss threshold, 1 samples per bit, 2 sync word
// samples above the threshold count as misses; after samples_per_bit samples
// the bit is voted (1 when misses >= hits); outside a message bits fill a
// sync window, inside they are packed msb first into bytes
// an input transaction reaches its result through the input register
// (holds the miss compare) and then the result register
// throughput: one sample per cycle unless a stalled receiver holds a result;
// vote, deframe and state update sit in one stage between the two registers
// a stalled receiver holds the result register; the input register takes one
// more sample, then in_ready stays low until the waiting result is taken
// reset: config returns to 100 / 64 / 0b101011, counters and framing cleared
module timing_bit_slicer_deframer_core #(
  parameter int unsigned MAX_MSG_BITS = tbsd_pkg::MAX_MSG_BITS_DEF,
  parameter int unsigned SYNC_BITS    = tbsd_pkg::SYNC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tbsd_pkg::TIME_W-1:0]          in_access_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tbsd_pkg::BYTE_W-1:0]          out_data_byte,
  output logic                                 out_end_of_message,
  output logic                                 out_truncated,
  input  logic                                 cfg_we,
  input  logic [tbsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tbsd_pkg::*;

  localparam int unsigned MBC_W = $clog2(MAX_MSG_BITS + 1);
  localparam logic [MBC_W-1:0] MAX_BITS = MBC_W'(MAX_MSG_BITS);

  // config
  logic [CNT_W-1:0]       miss_threshold_r;
  logic [CNT_W-1:0]       samples_per_bit_r;
  logic [SYNC_WORD_W-1:0] sync_word_r;

  // input stage
  logic s1_valid_r;
  logic s1_miss_r;

  // slicer / deframer state
  logic [CNT_W-1:0]     sample_count_r, sample_count_nxt;
  logic [CNT_W-1:0]     miss_count_r, miss_count_nxt;
  logic [SYNC_BITS-1:0] sync_window_r, sync_window_nxt;
  logic                 in_message_r, in_message_nxt;
  logic [BYTE_W-1:0]    byte_shift_r, byte_shift_nxt;
  logic [MBC_W-1:0]     msg_bits_r, msg_bits_nxt;

  // result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_eom_r;
  logic              out_trunc_r;

  logic                         advance;
  logic                         res_valid;
  logic [BYTE_W-1:0]            res_data;
  logic                         res_eom;
  logic                         res_trunc;
  logic [CNT_W-1:0]             need;
  logic [CNT_W-1:0]             samp_inc;
  logic [CNT_W-1:0]             miss_inc;
  logic                         vote_bit;
  logic [SYNC_BITS-1:0]         win_shift;
  logic [SYNC_BITS+SYNC_WORD_W-1:0] sync_ext;
  logic [SYNC_BITS-1:0]         sync_cmp;
  logic [BYTE_W-1:0]            byte_new;
  logic [MBC_W-1:0]             bits_inc;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    need      = (samples_per_bit_r == '0) ? CNT_W'(1) : samples_per_bit_r;
    samp_inc  = sample_count_r + CNT_W'(1);
    miss_inc  = miss_count_r + CNT_W'(s1_miss_r);
    vote_bit  = (miss_inc >= (samp_inc - miss_inc));
    win_shift = {sync_window_r[SYNC_BITS-2:0], vote_bit};
    sync_ext  = {{SYNC_BITS{1'b0}}, sync_word_r};
    sync_cmp  = sync_ext[SYNC_BITS-1:0];
    byte_new  = {byte_shift_r[BYTE_W-2:0], vote_bit};
    bits_inc  = msg_bits_r + MBC_W'(1);

    sample_count_nxt = samp_inc;
    miss_count_nxt   = miss_inc;
    sync_window_nxt  = sync_window_r;
    in_message_nxt   = in_message_r;
    byte_shift_nxt   = byte_shift_r;
    msg_bits_nxt     = msg_bits_r;
    res_valid        = 1'b0;
    res_data         = '0;
    res_eom          = 1'b0;
    res_trunc        = 1'b0;

    if (samp_inc >= need) begin
      sample_count_nxt = '0;
      miss_count_nxt   = '0;
      if (!in_message_r) begin
        sync_window_nxt = win_shift;
        if (win_shift == sync_cmp) begin
          in_message_nxt = 1'b1;
          byte_shift_nxt = '0;
          msg_bits_nxt   = '0;
        end
      end else begin
        byte_shift_nxt = byte_new;
        msg_bits_nxt   = bits_inc;
        if (bits_inc[2:0] == 3'd0) begin
          byte_shift_nxt = '0;
          res_valid      = 1'b1;
          priority if (byte_new == '0) begin
            in_message_nxt = 1'b0;
            msg_bits_nxt   = '0;
            res_eom        = 1'b1;
          end else if (bits_inc >= MAX_BITS) begin
            in_message_nxt = 1'b0;
            msg_bits_nxt   = '0;
            res_data       = byte_new;
            res_trunc      = 1'b1;
          end else begin
            res_data       = byte_new;
          end
        end else if (bits_inc >= MAX_BITS) begin
          in_message_nxt = 1'b0;
          msg_bits_nxt   = '0;
          byte_shift_nxt = '0;
          res_valid      = 1'b1;
          res_trunc      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_threshold_r  <= MISS_THRESHOLD_RST;
      samples_per_bit_r <= SAMPLES_PER_BIT_RST;
      sync_word_r       <= SYNC_WORD_RST;
      s1_valid_r        <= 1'b0;
      sample_count_r    <= '0;
      miss_count_r      <= '0;
      sync_window_r     <= '0;
      in_message_r      <= 1'b0;
      byte_shift_r      <= '0;
      msg_bits_r        <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MISS_THRESHOLD:  miss_threshold_r  <= cfg_wdata;
          CFG_SAMPLES_PER_BIT: samples_per_bit_r <= cfg_wdata;
          CFG_SYNC_WORD:       sync_word_r       <= cfg_wdata[SYNC_WORD_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        sample_count_r <= sample_count_nxt;
        miss_count_r   <= miss_count_nxt;
        sync_window_r  <= sync_window_nxt;
        in_message_r   <= in_message_nxt;
        byte_shift_r   <= byte_shift_nxt;
        msg_bits_r     <= msg_bits_nxt;
      end
      if (advance) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_miss_r <= (in_access_time > miss_threshold_r);
    end
    if (advance && res_valid) begin
      out_data_r  <= res_data;
      out_eom_r   <= res_eom;
      out_trunc_r <= res_trunc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_data_r;
  assign out_end_of_message = out_eom_r;
  assign out_truncated      = out_trunc_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_eom_r && out_trunc_r))
    else $error("end and truncated flags both set");

  a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eom_r) |-> (out_data_r == '0))
    else $error("end marker carries data");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_message_r |-> (msg_bits_r == '0))
    else $error("message bit count nonzero outside a message");

  a_bits_limit: assert property (@(posedge clk) disable iff (!rst_n)
    msg_bits_r < MAX_BITS)
    else $error("message bit count reached limit without ending");

  a_miss_le_samples: assert property (@(posedge clk) disable iff (!rst_n)
    miss_count_r <= sample_count_r)
    else $error("more misses than samples");

endmodule

[tb/tb_timing_bit_slicer_deframer_core.sv]
// testbench for timing_bit_slicer_deframer_core: directed and random timing samples
// checked against an in-bench slicer/deframer predictor; depends on tbsd_pkg and the core
`timescale 1ns / 1ps

module tb_timing_bit_slicer_deframer_core;
  import tbsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MSG_LIMIT    = MAX_MSG_BITS_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
    logic              truncated;
  } msg_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_access_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_data_byte;
  logic                  out_end_of_message;
  logic                  out_truncated;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and framing state
  logic [CNT_W-1:0]       thr_q = MISS_THRESHOLD_RST;
  logic [CNT_W-1:0]       spb_q = SAMPLES_PER_BIT_RST;
  logic [SYNC_WORD_W-1:0] sync_q = SYNC_WORD_RST;
  logic [CNT_W-1:0]       acc_samples = '0;
  logic [CNT_W-1:0]       acc_misses = '0;
  logic [SYNC_WORD_W-1:0] sync_shift = '0;
  logic                   framing = 1'b0;
  logic [BYTE_W-1:0]      byte_acc = '0;
  int unsigned            msg_bits = 0;

  msg_result_t pending_results[$];
  int unsigned samples_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bit_noise_pct = 0;

  timing_bit_slicer_deframer_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_access_time     (in_access_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_end_of_message (out_end_of_message),
    .out_truncated      (out_truncated),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    msg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data_byte %0h end_of_message %0b truncated %0b",
               out_data_byte, out_end_of_message, out_truncated);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", want.data_byte, out_data_byte);
          error_count++;
        end
        if (out_end_of_message !== want.end_of_message) begin
          $error("end_of_message: expected %0b, actual %0b",
                 want.end_of_message, out_end_of_message);
          error_count++;
        end
        if (out_truncated !== want.truncated) begin
          $error("truncated: expected %0b, actual %0b", want.truncated, out_truncated);
          error_count++;
        end
      end
    end
  end

  // one sample: miss count, bit vote, sync search or byte packing
  function automatic bit slice_and_deframe(input logic [TIME_W-1:0] t,
                                           output msg_result_t res);
    logic [CNT_W-1:0]  need;
    logic              vote;
    logic [BYTE_W-1:0] done_byte;
    res = '0;
    need = (spb_q == '0) ? CNT_W'(1) : spb_q;
    if (t > thr_q) acc_misses = acc_misses + 1'b1;
    acc_samples = acc_samples + 1'b1;
    if (acc_samples < need) return 1'b0;
    vote = (acc_misses >= CNT_W'(acc_samples - acc_misses));
    acc_samples = '0;
    acc_misses = '0;
    if (!framing) begin
      sync_shift = {sync_shift[SYNC_WORD_W-2:0], vote};
      if (sync_shift == sync_q) begin
        framing = 1'b1;
        byte_acc = '0;
        msg_bits = 0;
      end
      return 1'b0;
    end
    byte_acc = {byte_acc[BYTE_W-2:0], vote};
    msg_bits++;
    if (msg_bits % 8 == 0) begin
      done_byte = byte_acc;
      byte_acc = '0;
      if (done_byte == '0) begin
        framing = 1'b0;
        msg_bits = 0;
        res.end_of_message = 1'b1;
        return 1'b1;
      end
      res.data_byte = done_byte;
      if (msg_bits >= MSG_LIMIT) begin
        framing = 1'b0;
        msg_bits = 0;
        res.truncated = 1'b1;
      end
      return 1'b1;
    end
    if (msg_bits >= MSG_LIMIT) begin
      framing = 1'b0;
      msg_bits = 0;
      byte_acc = '0;
      res.truncated = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_sample(input logic [TIME_W-1:0] t);
    msg_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_access_time <= t;
    samples_sent++;
    if (slice_and_deframe(t, res)) pending_results.push_back(res);
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [TIME_W-1:0] pick_time(input bit miss);
    if (miss) return (thr_q == '1) ? '1 : TIME_W'($urandom_range(int'(thr_q) + 1, 65535));
    return TIME_W'($urandom_range(0, int'(thr_q)));
  endfunction

  task automatic send_bit(input bit b);
    int unsigned need;
    need = (spb_q == '0) ? 1 : spb_q;
    repeat (need) send_sample(pick_time(b ^ ($urandom_range(0, 99) < bit_noise_pct)));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    for (int i = BYTE_W - 1; i >= 0; i--) send_bit(value[i]);
  endtask

  task automatic send_sync();
    for (int i = SYNC_WORD_W - 1; i >= 0; i--) send_bit(sync_q[i]);
  endtask

  // registers change only with no transaction in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MISS_THRESHOLD:  thr_q = value;
      CFG_SAMPLES_PER_BIT: spb_q = value;
      CFG_SYNC_WORD:       sync_q = value[SYNC_WORD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_extremes();
    send_sample('0);
    send_sample('1);
    send_sample(MISS_THRESHOLD_RST);
    send_sample(MISS_THRESHOLD_RST + 1'b1);
  endtask

  // zero samples per bit acts as one; upper sync bits are ignored
  task automatic test_zero_spb_and_sync_mask();
    wait_idle();
    write_reg(CFG_SAMPLES_PER_BIT, '0);
    write_reg(CFG_MISS_THRESHOLD, 16'h7fff);
    write_reg(CFG_SYNC_WORD, 16'ha5e6);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sync();
    send_byte(8'h81);
    send_byte(8'h00);
  endtask

  task automatic test_spb_lowered_mid_bit();
    wait_idle();
    write_reg(CFG_SAMPLES_PER_BIT, '1);
    repeat (3) send_sample('1);
    wait_idle();
    write_reg(CFG_SAMPLES_PER_BIT, 16'd2);
    send_sample('1);
  endtask

  task automatic test_threshold_extremes();
    wait_idle();
    write_reg(CFG_SAMPLES_PER_BIT, 16'd1);
    write_reg(CFG_MISS_THRESHOLD, '0);
    send_sample('0);
    send_sample(16'd1);
    wait_idle();
    write_reg(CFG_MISS_THRESHOLD, '1);
    send_sample('1);
    send_sample('0);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_UNUSED, '1);
    send_sample('1);
    send_sample('0);
  endtask

  task automatic send_long_message(input bit zero_last);
    send_sync();
    repeat (MSG_LIMIT / BYTE_W - 1) send_byte(BYTE_W'($urandom_range(1, 255)));
    send_byte(zero_last ? '0 : BYTE_W'($urandom_range(1, 255)));
  endtask

  task automatic test_bit_limit_truncation();
    wait_idle();
    write_reg(CFG_SAMPLES_PER_BIT, 16'd1);
    write_reg(CFG_MISS_THRESHOLD, 16'd1000);
    write_reg(CFG_SYNC_WORD, CFG_DATA_W'(SYNC_WORD_RST));
    repeat (16) send_bit(1'b0);
    send_long_message(1'b0);
  endtask

  task automatic test_zero_byte_at_limit();
    send_long_message(1'b1);
  endtask

  task automatic pick_random_config();
    int unsigned r;
    wait_idle();
    r = $urandom_range(0, 9);
    write_reg(CFG_MISS_THRESHOLD, (r == 0) ? '0 : (r == 1) ? '1 :
              CFG_DATA_W'($urandom_range(1, 65534)));
    r = $urandom_range(0, 19);
    write_reg(CFG_SAMPLES_PER_BIT, (r == 0) ? '0 :
              (r < 3) ? CFG_DATA_W'($urandom_range(4, 10)) : CFG_DATA_W'($urandom_range(1, 3)));
    r = $urandom_range(0, 9);
    write_reg(CFG_SYNC_WORD, (r == 0) ? '0 : (r == 1) ? CFG_DATA_W'(63) :
              CFG_DATA_W'($urandom_range(0, 65535)));
    if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_frame();
    repeat ($urandom_range(0, 5)) send_byte(BYTE_W'($urandom_range(1, 255)));
    if ($urandom_range(0, 99) < 85) send_byte('0);
    else repeat ($urandom_range(1, 10)) send_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = samples_sent;
    while (samples_sent - start < count) begin
      if ($urandom_range(0, 99) < 20) pick_random_config();
      if ($urandom_range(0, 99) < 80) begin
        send_sync();
        send_random_frame();
      end else begin
        repeat ($urandom_range(1, 20)) send_sample(TIME_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    send_idle_pct = 27;
    recv_stall_pct = 71;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_extremes();
    test_zero_spb_and_sync_mask();
    test_spb_lowered_mid_bit();
    test_threshold_extremes();
    test_unused_index();

    bit_noise_pct = 4;
    run_random(RANDOM_ITEMS / 3);

    wait_idle();
    send_idle_pct = 71;
    recv_stall_pct = 27;
    run_random(RANDOM_ITEMS / 3);

    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bit_noise_pct = 0;
    test_bit_limit_truncation();
    test_zero_byte_at_limit();
    bit_noise_pct = 4;
    run_random(RANDOM_ITEMS / 3);

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
